FILE: hw/rtl/lwps_pkg.sv
package lwps_pkg;

  // coordinate width taken from each coordinate field
  localparam int COORD_BITS = 10;

  // descriptor queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // controller command bytes
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h29;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h28;

  // orientation offsets
  localparam logic [15:0] OFFSET_SMALL = 16'd20;
  localparam logic [15:0] OFFSET_LARGE = 16'd80;

  // configuration register index (byte address bit 2)
  localparam logic CFG_IDX_ORIENTATION = 1'b0;

  typedef enum logic [1:0] {
    OP_WINDOW = 2'd0,
    OP_GLYPH = 2'd1,
    OP_PIXEL = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORIENT_0 = 2'd0,
    ORIENT_1 = 2'd1,
    ORIENT_2 = 2'd2,
    ORIENT_3 = 2'd3
  } orient_t;

  // one classified request, ready for the byte sequencer
  // window: a x_start, b x_end, c y_start, d y_end (offsets applied)
  // glyph: a fg, b bg, bits dots; pixel: a color; display: bits[0] enable
  typedef struct packed {
    op_t op;
    logic [7:0] bits;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
  } desc_t;

  // index of the final byte of a run
  function automatic logic [3:0] run_last(op_t op);
    logic [3:0] r;
    unique case (op)
      OP_WINDOW: r = 4'd10;
      OP_GLYPH: r = 4'd15;
      OP_PIXEL: r = 4'd1;
      OP_DISPLAY: r = 4'd0;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/lcd_window_pixel_serializer.sv
// Drawing requests in, controller bytes out. A request is taken at a rising edge with start
// high and busy low; its bytes appear one per cycle on out_byte with strobe high: 11 bytes
// for a window, 16 for a glyph byte, 2 for a pixel and 1 for display on/off, the final
// one flagged by last_of_run. The byte sequencer emits one byte each cycle, and queued
// runs follow each other with no gap. A two-entry request queue sits in front of the
// sequencer; busy is high while it is full. The receiver cannot stall: every strobed byte
// must be taken in its cycle. orientation (address 0) should only be written while no run
// is pending.
module lcd_window_pixel_serializer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [lwps_pkg::COORD_BITS-1:0] x_start,
  input  logic [lwps_pkg::COORD_BITS-1:0] y_start,
  input  logic [lwps_pkg::COORD_BITS-1:0] x_end,
  input  logic [lwps_pkg::COORD_BITS-1:0] y_end,
  input  logic [7:0]                     glyph_bits,
  input  logic [15:0]                    fg_color,
  input  logic [15:0]                    bg_color,
  input  logic [15:0]                    pixel_color,
  input  logic                           display_enable,
  output logic                           strobe,
  output logic [7:0]                     out_byte,
  output logic                           is_data,
  output logic                           last_of_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [1:0]      orientation;
  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;
  lwps_pkg::desc_t push_desc;
  lwps_pkg::desc_t head;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == lwps_pkg::CFG_IDX_ORIENTATION)) begin
      orientation <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == lwps_pkg::CFG_IDX_ORIENTATION) ?
                  {30'd0, orientation} : 32'd0;

  assign busy = full;

  // request intake and classification
  lwps_front u_front (
    .start          (start),
    .full           (full),
    .orientation    (orientation),
    .operation      (operation),
    .x_start        (x_start),
    .y_start        (y_start),
    .x_end          (x_end),
    .y_end          (y_end),
    .glyph_bits     (glyph_bits),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .pixel_color    (pixel_color),
    .display_enable (display_enable),
    .push           (push),
    .desc           (push_desc)
  );

  // descriptor queue
  lwps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // byte sequencer
  lwps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .is_data     (is_data),
    .last_of_run (last_of_run)
  );

endmodule

FILE: hw/rtl/lwps_front.sv
module lwps_front (
  input  logic                           start,
  input  logic                           full,
  input  logic [1:0]                     orientation,
  input  logic [1:0]                     operation,
  input  logic [lwps_pkg::COORD_BITS-1:0] x_start,
  input  logic [lwps_pkg::COORD_BITS-1:0] y_start,
  input  logic [lwps_pkg::COORD_BITS-1:0] x_end,
  input  logic [lwps_pkg::COORD_BITS-1:0] y_end,
  input  logic [7:0]                     glyph_bits,
  input  logic [15:0]                    fg_color,
  input  logic [15:0]                    bg_color,
  input  logic [15:0]                    pixel_color,
  input  logic                           display_enable,
  output logic                           push,
  output lwps_pkg::desc_t                desc
);

  logic [15:0] xoff;
  logic [15:0] yoff;

  // a transfer is taken whenever the queue has room
  assign push = start && !full;

  // orientation offsets
  always_comb begin
    xoff = '0;
    yoff = '0;
    unique case (lwps_pkg::orient_t'(orientation))
      lwps_pkg::ORIENT_0: yoff = lwps_pkg::OFFSET_SMALL;
      lwps_pkg::ORIENT_1: yoff = lwps_pkg::OFFSET_LARGE;
      lwps_pkg::ORIENT_2: ;
      lwps_pkg::ORIENT_3: xoff = lwps_pkg::OFFSET_LARGE;
      default: ;
    endcase
  end

  // classify the request and pack its payload
  always_comb begin
    desc = '0;
    desc.op = lwps_pkg::op_t'(operation);
    unique case (lwps_pkg::op_t'(operation))
      lwps_pkg::OP_WINDOW: begin
        desc.a = 16'(x_start) + xoff;
        desc.b = 16'(x_end) + xoff;
        desc.c = 16'(y_start) + yoff;
        desc.d = 16'(y_end) + yoff;
      end
      lwps_pkg::OP_GLYPH: begin
        desc.bits = glyph_bits;
        desc.a = fg_color;
        desc.b = bg_color;
      end
      lwps_pkg::OP_PIXEL: begin
        desc.a = pixel_color;
      end
      lwps_pkg::OP_DISPLAY: begin
        desc.bits = {7'd0, display_enable};
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/lwps_queue.sv
module lwps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lwps_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lwps_pkg::desc_t head
);

  lwps_pkg::desc_t entries [lwps_pkg::QUEUE_DEPTH];
  logic [lwps_pkg::QPTR_BITS-1:0] wptr;
  logic [lwps_pkg::QPTR_BITS-1:0] rptr;
  logic [lwps_pkg::QCOUNT_BITS-1:0] count;

  localparam logic [lwps_pkg::QPTR_BITS-1:0] PtrLast =
    lwps_pkg::QPTR_BITS'(lwps_pkg::QUEUE_DEPTH - 1);
  localparam logic [lwps_pkg::QCOUNT_BITS-1:0] CountFull =
    lwps_pkg::QCOUNT_BITS'(lwps_pkg::QUEUE_DEPTH);

  assign full = (count == CountFull);
  assign not_empty = (count != '0);
  assign head = entries[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (rst) count <= CountFull)
    else $error("queue count beyond depth");

  // a push into a non-full queue without a pop grows it by one
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

FILE: hw/rtl/lwps_back.sv
module lwps_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  lwps_pkg::desc_t head,
  output logic            pop,
  output logic            strobe,
  output logic [7:0]      out_byte,
  output logic            is_data,
  output logic            last_of_run
);

  lwps_pkg::desc_t cur;
  logic            active;
  logic [3:0]      idx;
  logic            at_last;
  logic [2:0]      pix;
  logic            dot;
  logic [15:0]     color;

  assign at_last = (idx == lwps_pkg::run_last(cur.op));

  // take the next descriptor while idle or on the last byte of a run
  assign pop = not_empty && (!active || at_last);

  // run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx <= '0;
    end else if (active && at_last) begin
      active <= 1'b0;
    end else if (active) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // glyph dot selection, bit 7 first
  assign pix = idx[3:1];
  assign dot = cur.bits[~pix];
  assign color = dot ? cur.a : cur.b;

  // byte selection for the current run position
  always_comb begin
    out_byte = '0;
    is_data = 1'b1;
    unique case (cur.op)
      lwps_pkg::OP_WINDOW: begin
        unique case (idx)
          4'd0: begin
            out_byte = lwps_pkg::CMD_COLUMN_SET;
            is_data = 1'b0;
          end
          4'd1: out_byte = cur.a[15:8];
          4'd2: out_byte = cur.a[7:0];
          4'd3: out_byte = cur.b[15:8];
          4'd4: out_byte = cur.b[7:0];
          4'd5: begin
            out_byte = lwps_pkg::CMD_ROW_SET;
            is_data = 1'b0;
          end
          4'd6: out_byte = cur.c[15:8];
          4'd7: out_byte = cur.c[7:0];
          4'd8: out_byte = cur.d[15:8];
          4'd9: out_byte = cur.d[7:0];
          default: begin
            out_byte = lwps_pkg::CMD_MEMORY_WRITE;
            is_data = 1'b0;
          end
        endcase
      end
      lwps_pkg::OP_GLYPH: begin
        out_byte = idx[0] ? color[7:0] : color[15:8];
      end
      lwps_pkg::OP_PIXEL: begin
        out_byte = idx[0] ? cur.a[7:0] : cur.a[15:8];
      end
      lwps_pkg::OP_DISPLAY: begin
        out_byte = cur.bits[0] ? lwps_pkg::CMD_DISPLAY_ON : lwps_pkg::CMD_DISPLAY_OFF;
        is_data = 1'b0;
      end
      default: ;
    endcase
  end

  assign strobe = active;
  assign last_of_run = active && at_last;

  // a run is never broken before its last byte
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_run) |=> strobe)
    else $error("run ended before its last byte");

  // the run position advances by one between bytes of a run
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_run) |=> (idx == $past(idx) + 1'b1))
    else $error("run position skipped");

endmodule
